// ===== src/vsa_pkg.sv =====
// vsa_pkg: shared types, constants and helpers for the versioned slot allocator
// no dependencies; used by every module of the block
package vsa_pkg;

  localparam int INDEX_BITS = 10;
  localparam int GEN_BITS   = 8;
  localparam int ROLE_BITS  = 2;
  localparam int HANDLE_W   = ROLE_BITS + GEN_BITS + INDEX_BITS;
  localparam int OWNER_W    = 31;
  localparam int CFG_W      = 11;
  localparam int SLOTS      = 1 << INDEX_BITS;
  localparam int LINK_W     = INDEX_BITS + 1;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [LINK_W-1:0]     link_t;
  typedef logic [GEN_BITS-1:0]   gen_t;
  typedef logic [ROLE_BITS-1:0]  role_t;
  typedef logic [OWNER_W-1:0]    owner_t;
  typedef logic [HANDLE_W-1:0]   handle_t;
  typedef logic [1:0]            opcode_t;
  typedef logic [2:0]            status_t;

  localparam link_t NO_LINK = link_t'(SLOTS);
  localparam gen_t  GEN_MAX = '1;

  localparam opcode_t OP_ALLOC   = 2'd0;
  localparam opcode_t OP_CLAIM   = 2'd1;
  localparam opcode_t OP_RELEASE = 2'd2;
  localparam opcode_t OP_UPDATE  = 2'd3;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_BAD_INDEX = 3'd2;
  localparam status_t ST_NOT_USED  = 3'd3;
  localparam status_t ST_IN_USE    = 3'd4;

  typedef struct packed {
    opcode_t opcode;
    handle_t handle;
    handle_t second_handle;
    owner_t  owner;
    role_t   role;
  } req_t;

  typedef struct packed {
    status_t status;
    handle_t new_handle;
  } rsp_t;

  typedef struct packed {
    link_t  prev_link;
    link_t  next_link;
    gen_t   generation;
    owner_t slot_owner;
  } entry_t;

  typedef struct packed {
    logic prev_link;
    logic next_link;
    logic generation;
    logic slot_owner;
  } fld_mask_t;

  typedef struct packed {
    logic      rd_en;
    idx_t      rd_addr;
    fld_mask_t wr_en;
    idx_t      wr_addr;
    entry_t    wr_data;
  } tbl_req_t;

  function automatic idx_t handle_idx(input handle_t h);
    return h[INDEX_BITS-1:0];
  endfunction

  function automatic gen_t handle_gen(input handle_t h);
    return h[INDEX_BITS +: GEN_BITS];
  endfunction

  function automatic logic idx_in_range(input idx_t i, input link_t cnt);
    return {1'b0, i} < cnt;
  endfunction

  function automatic link_t clamp_count(input logic [CFG_W-1:0] v);
    link_t r;
    if (v == '0) begin
      r = link_t'(1);
    end else if (32'(v) > 32'(SLOTS)) begin
      r = link_t'(SLOTS);
    end else begin
      r = link_t'(v);
    end
    return r;
  endfunction

endpackage

// ===== src/vsa_table.sv =====
// vsa_table: slot table memory holding links, generation and owner per slot
// one read port with registered data, one write port with per-field enables; uses vsa_pkg
module vsa_table (
  input  logic              clk,
  input  vsa_pkg::tbl_req_t tbl,
  output vsa_pkg::entry_t   rd_data
);

  vsa_pkg::entry_t mem [vsa_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (tbl.wr_en.prev_link) begin
      mem[tbl.wr_addr].prev_link <= tbl.wr_data.prev_link;
    end
    if (tbl.wr_en.next_link) begin
      mem[tbl.wr_addr].next_link <= tbl.wr_data.next_link;
    end
    if (tbl.wr_en.generation) begin
      mem[tbl.wr_addr].generation <= tbl.wr_data.generation;
    end
    if (tbl.wr_en.slot_owner) begin
      mem[tbl.wr_addr].slot_owner <= tbl.wr_data.slot_owner;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl.rd_en) begin
      rd_data <= mem[tbl.rd_addr];
    end
  end

endmodule

// ===== src/vsa_ctrl.sv =====
// vsa_ctrl: operation sequencer, list head registers and table clearing sweep
// drives the vsa_table port one access per cycle; uses vsa_pkg
module vsa_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [vsa_pkg::CFG_W-1:0]   cfg_value,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  vsa_pkg::req_t               req,
  input  logic                        out_free,
  output logic                        done,
  output vsa_pkg::rsp_t               result,
  output vsa_pkg::tbl_req_t           tbl,
  input  vsa_pkg::entry_t             tbl_rd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_W1     = 4'd3;
  localparam logic [3:0] S_W2     = 4'd4;
  localparam logic [3:0] S_W3     = 4'd5;
  localparam logic [3:0] S_W4     = 4'd6;
  localparam logic [3:0] S_RD2    = 4'd7;
  localparam logic [3:0] S_CHECK2 = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]       state;
  vsa_pkg::link_t   cnt;
  vsa_pkg::idx_t    clr_idx;
  vsa_pkg::link_t   free_head;
  vsa_pkg::link_t   free_tail;
  vsa_pkg::link_t   used_head;
  vsa_pkg::req_t    cur;
  vsa_pkg::idx_t    slot;
  vsa_pkg::link_t   p_link;
  vsa_pkg::link_t   n_link;
  vsa_pkg::entry_t  w3;
  logic             w4_en;
  logic             w4_on_next;
  vsa_pkg::idx_t    w4_addr;

  vsa_pkg::link_t   slot_link;
  vsa_pkg::link_t   clr_link;
  vsa_pkg::link_t   clr_succ;
  vsa_pkg::idx_t    idx2;
  vsa_pkg::gen_t    take_gen;
  vsa_pkg::status_t chk_status;
  vsa_pkg::status_t chk2_status;
  vsa_pkg::link_t   new_cnt;

  assign slot_link = {1'b0, slot};
  assign clr_link  = {1'b0, clr_idx};
  assign clr_succ  = clr_link + vsa_pkg::link_t'(1);
  assign idx2      = vsa_pkg::handle_idx(cur.second_handle);
  assign take_gen  = (cur.opcode == vsa_pkg::OP_ALLOC) ?
                     tbl_rd.generation + vsa_pkg::gen_t'(1) :
                     vsa_pkg::handle_gen(cur.handle);
  assign new_cnt   = vsa_pkg::clamp_count(cfg_value);
  assign req_stall = (state != S_IDLE);
  assign done      = (state == S_DONE) && out_free;

  always_comb begin
    case (cur.opcode)
      vsa_pkg::OP_ALLOC: begin
        chk_status = (free_head == vsa_pkg::NO_LINK) ? vsa_pkg::ST_FULL : vsa_pkg::ST_OK;
      end
      vsa_pkg::OP_CLAIM: begin
        if (!vsa_pkg::idx_in_range(slot, cnt)) begin
          chk_status = vsa_pkg::ST_BAD_INDEX;
        end else if (tbl_rd.slot_owner != '0) begin
          chk_status = vsa_pkg::ST_IN_USE;
        end else begin
          chk_status = vsa_pkg::ST_OK;
        end
      end
      default: begin
        if (!vsa_pkg::idx_in_range(slot, cnt)) begin
          chk_status = vsa_pkg::ST_BAD_INDEX;
        end else if (tbl_rd.slot_owner == '0) begin
          chk_status = vsa_pkg::ST_NOT_USED;
        end else begin
          chk_status = vsa_pkg::ST_OK;
        end
      end
    endcase
  end

  always_comb begin
    if (!vsa_pkg::idx_in_range(idx2, cnt)) begin
      chk2_status = vsa_pkg::ST_BAD_INDEX;
    end else if (tbl_rd.slot_owner == '0) begin
      chk2_status = vsa_pkg::ST_NOT_USED;
    end else begin
      chk2_status = vsa_pkg::ST_OK;
    end
  end

  // table port: one read or one write a cycle, writes in list order
  always_comb begin
    tbl = '0;
    case (state)
      S_CLEAR: begin
        tbl.wr_en   = '1;
        tbl.wr_addr = clr_idx;
        tbl.wr_data.prev_link = (clr_idx == '0 || !vsa_pkg::idx_in_range(clr_idx, cnt)) ?
                                vsa_pkg::NO_LINK : clr_link - vsa_pkg::link_t'(1);
        tbl.wr_data.next_link = (clr_succ < cnt) ? clr_succ : vsa_pkg::NO_LINK;
      end
      S_IDLE: begin
        tbl.rd_en   = req_valid;
        tbl.rd_addr = (req.opcode == vsa_pkg::OP_ALLOC) ?
                      free_head[vsa_pkg::INDEX_BITS-1:0] : vsa_pkg::handle_idx(req.handle);
      end
      S_CHECK: begin
        tbl.wr_en.slot_owner = (cur.opcode == vsa_pkg::OP_UPDATE) &&
                               (chk_status == vsa_pkg::ST_OK);
        tbl.wr_addr            = slot;
        tbl.wr_data.slot_owner = cur.owner;
      end
      S_W1: begin
        tbl.wr_en.next_link   = (p_link != vsa_pkg::NO_LINK);
        tbl.wr_addr           = p_link[vsa_pkg::INDEX_BITS-1:0];
        tbl.wr_data.next_link = n_link;
      end
      S_W2: begin
        tbl.wr_en.prev_link   = (n_link != vsa_pkg::NO_LINK);
        tbl.wr_addr           = n_link[vsa_pkg::INDEX_BITS-1:0];
        tbl.wr_data.prev_link = p_link;
      end
      S_W3: begin
        tbl.wr_en   = '1;
        tbl.wr_addr = slot;
        tbl.wr_data = w3;
      end
      S_W4: begin
        tbl.wr_en.prev_link   = w4_en && !w4_on_next;
        tbl.wr_en.next_link   = w4_en && w4_on_next;
        tbl.wr_addr           = w4_addr;
        tbl.wr_data.prev_link = slot_link;
        tbl.wr_data.next_link = slot_link;
      end
      S_RD2: begin
        tbl.rd_en   = 1'b1;
        tbl.rd_addr = idx2;
      end
      S_CHECK2: begin
        tbl.wr_en.slot_owner   = (chk2_status == vsa_pkg::ST_OK);
        tbl.wr_addr            = idx2;
        tbl.wr_data.slot_owner = cur.owner;
      end
      default: begin
        tbl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= vsa_pkg::link_t'(vsa_pkg::SLOTS);
      clr_idx   <= '0;
      free_head <= '0;
      free_tail <= vsa_pkg::link_t'(vsa_pkg::SLOTS - 1);
      used_head <= vsa_pkg::NO_LINK;
    end else if (cfg_wr_en) begin
      state     <= S_CLEAR;
      cnt       <= new_cnt;
      clr_idx   <= '0;
      free_head <= '0;
      free_tail <= new_cnt - vsa_pkg::link_t'(1);
      used_head <= vsa_pkg::NO_LINK;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + vsa_pkg::idx_t'(1);
          if (&clr_idx) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            slot  <= (req.opcode == vsa_pkg::OP_ALLOC) ?
                     free_head[vsa_pkg::INDEX_BITS-1:0] : vsa_pkg::handle_idx(req.handle);
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          p_link            <= tbl_rd.prev_link;
          n_link            <= tbl_rd.next_link;
          result.status     <= chk_status;
          result.new_handle <= '0;
          state             <= S_DONE;
          if (chk_status == vsa_pkg::ST_OK) begin
            case (cur.opcode)
              vsa_pkg::OP_ALLOC, vsa_pkg::OP_CLAIM: begin
                // unlink from the free list, push on the used head
                if (slot_link == free_tail) begin
                  free_tail <= tbl_rd.prev_link;
                end
                if (tbl_rd.prev_link == vsa_pkg::NO_LINK) begin
                  free_head <= tbl_rd.next_link;
                end
                w3.prev_link  <= vsa_pkg::NO_LINK;
                w3.next_link  <= used_head;
                w3.generation <= take_gen;
                w3.slot_owner <= cur.owner;
                w4_en         <= (used_head != vsa_pkg::NO_LINK);
                w4_on_next    <= 1'b0;
                w4_addr       <= used_head[vsa_pkg::INDEX_BITS-1:0];
                used_head     <= slot_link;
                if (cur.opcode == vsa_pkg::OP_ALLOC) begin
                  result.new_handle <= {cur.role, take_gen, slot};
                end
                state <= S_W1;
              end
              vsa_pkg::OP_RELEASE: begin
                if (tbl_rd.prev_link == vsa_pkg::NO_LINK) begin
                  used_head <= tbl_rd.next_link;
                end
                w3.generation <= tbl_rd.generation;
                w3.slot_owner <= '0;
                if (tbl_rd.generation != vsa_pkg::GEN_MAX) begin
                  w3.prev_link <= vsa_pkg::NO_LINK;
                  w3.next_link <= free_head;
                  w4_en        <= (free_head != vsa_pkg::NO_LINK);
                  w4_on_next   <= 1'b0;
                  w4_addr      <= free_head[vsa_pkg::INDEX_BITS-1:0];
                  if (free_head == vsa_pkg::NO_LINK) begin
                    free_tail <= slot_link;
                  end
                  free_head <= slot_link;
                end else begin
                  // wrapped generation cools down at the free tail
                  w3.prev_link <= free_tail;
                  w3.next_link <= vsa_pkg::NO_LINK;
                  w4_en        <= (free_tail != vsa_pkg::NO_LINK);
                  w4_on_next   <= 1'b1;
                  w4_addr      <= free_tail[vsa_pkg::INDEX_BITS-1:0];
                  if (free_tail == vsa_pkg::NO_LINK) begin
                    free_head <= slot_link;
                  end
                  free_tail <= slot_link;
                end
                state <= S_W1;
              end
              default: begin
                if (cur.handle != cur.second_handle) begin
                  state <= S_RD2;
                end
              end
            endcase
          end
        end
        S_W1: begin
          state <= S_W2;
        end
        S_W2: begin
          state <= S_W3;
        end
        S_W3: begin
          state <= S_W4;
        end
        S_W4: begin
          state <= S_DONE;
        end
        S_RD2: begin
          state <= S_CHECK2;
        end
        S_CHECK2: begin
          result.status <= chk2_status;
          state         <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/versioned_slot_allocator_top.sv =====
// versioned_slot_allocator_top: slot allocator with free and used lists and generations
// one beat at a time; allocate, claim and release run the check and four table writes,
// an error only the check, a two-handle update a second read and check; next beat taken
// once the result is in the output register; the single write port sets the pace
// reset or a slots_in_use write starts a sweep of every slot, stall held high meanwhile
module versioned_slot_allocator_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [vsa_pkg::CFG_W-1:0] slots_in_use,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  vsa_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output vsa_pkg::rsp_t             rsp
);

  vsa_pkg::tbl_req_t tbl;
  vsa_pkg::entry_t   tbl_rd;
  vsa_pkg::rsp_t     result;
  logic              done;
  logic              out_free;

  assign out_free = !rsp_valid || !rsp_stall;

  vsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_value (slots_in_use),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .out_free  (out_free),
    .done      (done),
    .result    (result),
    .tbl       (tbl),
    .tbl_rd    (tbl_rd)
  );

  vsa_table u_table (
    .clk     (clk),
    .tbl     (tbl),
    .rd_data (tbl_rd)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp <= result;
    end
  end

endmodule

// ===== src/vsa_checker.sv =====
// vsa_checker: port-level checks for the versioned slot allocator
// bound to versioned_slot_allocator_top; uses vsa_pkg
module vsa_checker (
  input logic          clk,
  input logic          rst,
  input logic          cfg_wr_en,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input vsa_pkg::rsp_t rsp
);

  // stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  // only a successful allocate carries a handle
  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != vsa_pkg::ST_OK |-> rsp.new_handle == '0)
    else $error("handle on a failed result");

  // table sweep after reset
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken during table sweep after reset");

  // table sweep after a count write
  a_cfg_sweep: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> req_stall)
    else $error("request taken during table sweep after count write");

  // one beat at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while one is in work");

endmodule

bind versioned_slot_allocator_top vsa_checker u_vsa_checker (.*);

// ===== verif/tb_versioned_slot_allocator_top.sv =====
// testbench for versioned_slot_allocator_top: a directed table then random mixes of allocate,
// claim, release and update beats over several slot counts, checked against an in-bench table
// depends on vsa_pkg and versioned_slot_allocator_top
`timescale 1ns / 100ps

module tb_versioned_slot_allocator_top;
  import vsa_pkg::*;

  typedef struct {
    int      new_count;
    req_t    rq;
    bit      typed;
    rsp_t    want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wr_en;
  logic [CFG_W-1:0]  slots_in_use;
  logic              req_valid;
  logic              req_stall;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;

  // shadow slot table
  link_t  t_prev [SLOTS];
  link_t  t_next [SLOTS];
  gen_t   t_gen  [SLOTS];
  owner_t t_own  [SLOTS];
  link_t  free_hd;
  link_t  free_tl;
  link_t  used_hd;
  link_t  n_managed;

  rsp_t      owed_replies [$];
  plan_row_t plan [$];
  rsp_t      want;
  int        send_pct = 0;
  int        recv_pct = 0;
  int        n_fail = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_settings = 0;
  int        seen_status [5];

  versioned_slot_allocator_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .slots_in_use (slots_in_use),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp)
  );

  always #2 clk = ~clk;

  function automatic void put_prev(input link_t i, input link_t v);
    if (i < SLOTS) begin
      t_prev[i[INDEX_BITS-1:0]] = v;
    end
  endfunction

  function automatic void put_next(input link_t i, input link_t v);
    if (i < SLOTS) begin
      t_next[i[INDEX_BITS-1:0]] = v;
    end
  endfunction

  function automatic void table_rebuild(input link_t n);
    int i;
    for (i = 0; i < SLOTS; i++) begin
      t_gen[i] = '0;
      t_own[i] = '0;
      if (i < n) begin
        t_prev[i] = (i == 0) ? NO_LINK : link_t'(i - 1);
        t_next[i] = (i + 1 < n) ? link_t'(i + 1) : NO_LINK;
      end else begin
        t_prev[i] = NO_LINK;
        t_next[i] = NO_LINK;
      end
    end
    n_managed = n;
    free_hd = '0;
    free_tl = n - 1'b1;
    used_hd = NO_LINK;
  endfunction

  function automatic void drop_free(input idx_t s);
    link_t p;
    link_t nx;
    p = t_prev[s];
    nx = t_next[s];
    if (link_t'(s) == free_tl) begin
      free_tl = p;
    end
    if (p == NO_LINK) begin
      free_hd = nx;
      if (nx != NO_LINK) put_prev(nx, NO_LINK);
    end else begin
      put_next(p, nx);
      if (nx != NO_LINK) put_prev(nx, p);
    end
  endfunction

  function automatic void drop_used(input idx_t s);
    link_t p;
    link_t nx;
    p = t_prev[s];
    nx = t_next[s];
    if (p == NO_LINK) begin
      used_hd = nx;
      if (nx != NO_LINK) put_prev(nx, NO_LINK);
    end else begin
      put_next(p, nx);
      if (nx != NO_LINK) put_prev(nx, p);
    end
  endfunction

  function automatic void push_used(input idx_t s);
    t_prev[s] = NO_LINK;
    t_next[s] = used_hd;
    if (used_hd != NO_LINK) put_prev(used_hd, link_t'(s));
    used_hd = link_t'(s);
  endfunction

  // slots at the top generation cool down at the free tail
  function automatic void push_free(input idx_t s);
    if (t_gen[s] != GEN_MAX) begin
      t_prev[s] = NO_LINK;
      t_next[s] = free_hd;
      if (free_hd != NO_LINK) put_prev(free_hd, link_t'(s));
      else free_tl = link_t'(s);
      free_hd = link_t'(s);
    end else begin
      t_prev[s] = free_tl;
      t_next[s] = NO_LINK;
      if (free_tl != NO_LINK) put_next(free_tl, link_t'(s));
      else free_hd = link_t'(s);
      free_tl = link_t'(s);
    end
  endfunction

  function automatic status_t write_owner(input handle_t h, input owner_t o);
    idx_t s;
    s = h[INDEX_BITS-1:0];
    if (link_t'(s) >= n_managed) return ST_BAD_INDEX;
    if (t_own[s] == '0) return ST_NOT_USED;
    t_own[s] = o;
    return ST_OK;
  endfunction

  function automatic rsp_t table_step(input req_t r);
    rsp_t o;
    idx_t s;
    idx_t f;
    o.status = ST_OK;
    o.new_handle = '0;
    s = r.handle[INDEX_BITS-1:0];
    case (r.opcode)
      OP_ALLOC: begin
        if (free_hd >= SLOTS) begin
          o.status = ST_FULL;
        end else begin
          f = free_hd[INDEX_BITS-1:0];
          t_gen[f] = t_gen[f] + 1'b1;
          t_own[f] = r.owner;
          drop_free(f);
          push_used(f);
          o.new_handle = {r.role, t_gen[f], f};
        end
      end
      OP_CLAIM: begin
        if (link_t'(s) >= n_managed) begin
          o.status = ST_BAD_INDEX;
        end else if (t_own[s] != '0) begin
          o.status = ST_IN_USE;
        end else begin
          t_gen[s] = r.handle[INDEX_BITS +: GEN_BITS];
          t_own[s] = r.owner;
          drop_free(s);
          push_used(s);
        end
      end
      OP_RELEASE: begin
        if (link_t'(s) >= n_managed) begin
          o.status = ST_BAD_INDEX;
        end else if (t_own[s] == '0) begin
          o.status = ST_NOT_USED;
        end else begin
          t_own[s] = '0;
          drop_used(s);
          push_free(s);
        end
      end
      OP_UPDATE: begin
        o.status = write_owner(r.handle, r.owner);
        if (o.status == ST_OK && r.second_handle != r.handle) begin
          o.status = write_owner(r.second_handle, r.owner);
        end
      end
    endcase
    return o;
  endfunction

  function automatic bit pick_slot(input bit busy, output idx_t s);
    int unsigned base;
    int unsigned j;
    int unsigned cnt;
    cnt = n_managed;
    base = $urandom_range(cnt - 1);
    s = '0;
    for (j = 0; j < cnt; j++) begin
      s = idx_t'((base + j) % cnt);
      if ((t_own[s] != '0) == busy) return 1'b1;
    end
    return 1'b0;
  endfunction

  // mostly legal traffic aimed at live or free slots, the rest raw noise
  function automatic req_t draw_req();
    req_t r;
    idx_t s;
    int unsigned pick;
    r.opcode = OP_ALLOC;
    r.handle = handle_t'($urandom);
    r.second_handle = handle_t'($urandom);
    r.owner = owner_t'($urandom);
    r.role = role_t'($urandom);
    if ($urandom_range(15) == 0) r.owner = '0;
    pick = $urandom_range(99);
    if (pick < 30) begin
      r.opcode = OP_ALLOC;
    end else if (pick < 52) begin
      r.opcode = OP_RELEASE;
      if (pick_slot(1'b1, s)) r.handle[INDEX_BITS-1:0] = s;
    end else if (pick < 67) begin
      r.opcode = OP_CLAIM;
      if (pick_slot(1'b0, s)) r.handle[INDEX_BITS-1:0] = s;
      if ($urandom_range(7) == 0) r.handle[INDEX_BITS +: GEN_BITS] = GEN_MAX;
    end else if (pick < 82) begin
      r.opcode = OP_UPDATE;
      if (pick_slot(1'b1, s)) r.handle[INDEX_BITS-1:0] = s;
      if ($urandom_range(1) == 1) begin
        r.second_handle = r.handle;
      end else if (pick_slot(1'b1, s)) begin
        r.second_handle[INDEX_BITS-1:0] = s;
      end
    end else begin
      r.opcode = opcode_t'($urandom);
    end
    return r;
  endfunction

  task automatic add_row(input int cnt, input opcode_t op, input handle_t h, input handle_t h2,
                         input owner_t o, input role_t rl, input bit typed,
                         input status_t st, input handle_t nh);
    plan_row_t row;
    row.new_count = cnt;
    row.rq.opcode = op;
    row.rq.handle = h;
    row.rq.second_handle = h2;
    row.rq.owner = o;
    row.rq.role = rl;
    row.typed = typed;
    row.want.status = st;
    row.want.new_handle = nh;
    plan.push_back(row);
  endtask

  task automatic offer_request(input req_t r, input bit typed, input rsp_t fixed);
    rsp_t got;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    got = table_step(r);
    owed_replies.push_back(typed ? fixed : got);
    n_sent++;
  endtask

  task automatic wait_replies();
    req_valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
  endtask

  task automatic set_count(input logic [CFG_W-1:0] v);
    link_t n;
    wait_replies();
    repeat (10) @(posedge clk);
    cfg_wr_en <= 1'b1;
    slots_in_use <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (v == '0) n = link_t'(1);
    else if (v > SLOTS) n = link_t'(SLOTS);
    else n = link_t'(v);
    table_rebuild(n);
    n_settings++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (owed_replies.size() == 0) begin
          $error("unexpected beat: status %0d new_handle %h", rsp.status, rsp.new_handle);
          n_fail++;
        end else begin
          want = owed_replies.pop_front();
          if (rsp.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            n_fail++;
          end
          if (rsp.new_handle != want.new_handle) begin
            $error("new_handle: expected %h, got %h", want.new_handle, rsp.new_handle);
            n_fail++;
          end
          if (rsp.status < 5) seen_status[rsp.status]++;
          n_checked++;
        end
      end
      rsp_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
    end
  end

  initial begin
    #2400000;
    $display("** versioned_slot_allocator_top: FAILED **");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] phase_counts [10];
    plan_row_t row;
    rsp_t none;
    int p;
    int k;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    slots_in_use = '0;
    req_valid = 1'b0;
    req = '0;
    none = '0;
    phase_counts = '{11'd5, 11'd1024, 11'd2, 11'd2047, 11'd16, 11'd1, 11'd1025, 11'd3,
                     11'd64, 11'd0};
    for (k = 0; k < 5; k++) seen_status[k] = 0;
    table_rebuild(link_t'(SLOTS));

    add_row(-1, OP_ALLOC, '0, '0, 31'd1, 2'd0, 1, ST_OK, {2'd0, 8'd1, 10'd0});
    add_row(-1, OP_ALLOC, '1, '1, 31'h7FFFFFFF, 2'd3, 1, ST_OK, {2'd3, 8'd1, 10'd1});
    add_row(-1, OP_CLAIM, {2'd3, 8'hFF, 10'd1023}, '0, 31'd5, 2'd0, 1, ST_OK, '0);
    add_row(-1, OP_CLAIM, {2'd0, 8'h00, 10'd1023}, '0, 31'd5, 2'd0, 1, ST_IN_USE, '0);
    add_row(-1, OP_RELEASE, {2'd3, 8'hFF, 10'd1023}, '0, 31'd0, 2'd0, 0, ST_OK, '0);
    add_row(-1, OP_RELEASE, {2'd0, 8'h00, 10'd1023}, '0, 31'd0, 2'd0, 1, ST_NOT_USED, '0);
    add_row(-1, OP_UPDATE, '0, '0, 31'h1234, 2'd0, 0, ST_OK, '0);
    add_row(-1, OP_UPDATE, '0, {2'd3, 8'hFF, 10'd1}, 31'd9, 2'd0, 0, ST_OK, '0);
    add_row(-1, OP_UPDATE, {2'd0, 8'd0, 10'd1}, {2'd0, 8'd0, 10'd5}, 31'd8, 2'd0, 1,
            ST_NOT_USED, '0);
    // owner zero leaves the slot linked but reading as free
    add_row(-1, OP_ALLOC, '0, '0, 31'd0, 2'd2, 0, ST_OK, '0);
    add_row(-1, OP_RELEASE, {2'd0, 8'd0, 10'd2}, '0, 31'd0, 2'd0, 0, ST_OK, '0);
    add_row(-1, OP_CLAIM, {2'd0, 8'd3, 10'd2}, '0, 31'd6, 2'd0, 0, ST_OK, '0);
    add_row(-1, OP_RELEASE, '0, '0, 31'd0, 2'd0, 0, ST_OK, '0);
    add_row(-1, OP_ALLOC, '0, '0, 31'hAAAA, 2'd1, 0, ST_OK, '0);
    add_row(3, OP_CLAIM, {2'd0, 8'd0, 10'd3}, '0, 31'd2, 2'd0, 1, ST_BAD_INDEX, '0);
    add_row(-1, OP_RELEASE, '1, '0, 31'd0, 2'd0, 1, ST_BAD_INDEX, '0);
    add_row(-1, OP_ALLOC, '0, '0, 31'd3, 2'd0, 1, ST_OK, {2'd0, 8'd1, 10'd0});
    add_row(-1, OP_UPDATE, '0, {2'd0, 8'd0, 10'd3}, 31'd4, 2'd0, 1, ST_BAD_INDEX, '0);
    add_row(-1, OP_UPDATE, {2'd0, 8'd0, 10'd3}, '0, 31'd4, 2'd0, 1, ST_BAD_INDEX, '0);
    add_row(-1, OP_ALLOC, '0, '0, 31'd11, 2'd1, 0, ST_OK, '0);
    add_row(-1, OP_ALLOC, '0, '0, 31'd12, 2'd2, 0, ST_OK, '0);
    add_row(-1, OP_ALLOC, '0, '0, 31'd13, 2'd3, 1, ST_FULL, '0);
    add_row(-1, OP_CLAIM, {2'd0, 8'd0, 10'd1}, '0, 31'd14, 2'd0, 1, ST_IN_USE, '0);
    add_row(0, OP_ALLOC, '0, '0, 31'd1, 2'd0, 1, ST_OK, {2'd0, 8'd1, 10'd0});
    add_row(-1, OP_ALLOC, '0, '0, 31'd1, 2'd0, 1, ST_FULL, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      row = plan[k];
      if (row.new_count >= 0) set_count(CFG_W'(row.new_count));
      offer_request(row.rq, row.typed, row.want);
    end

    for (p = 0; p < 10; p++) begin
      set_count(phase_counts[p]);
      case (p % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 50; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 50; end
        default: begin send_pct = 13; recv_pct = 13; end
      endcase
      for (k = 0; k < 113; k++) begin
        if (k == 60) wait_replies();
        offer_request(draw_req(), 1'b0, none);
      end
    end

    wait_replies();
    repeat (20) @(posedge clk);
    $display("%0d request beats sent, %0d reply beats checked, %0d slot counts written",
             n_sent, n_checked, n_settings);
    $display("replies ok %0d, full %0d, bad index %0d, not in use %0d, already in use %0d",
             seen_status[0], seen_status[1], seen_status[2], seen_status[3], seen_status[4]);
    if (n_fail == 0) begin
      $display("** versioned_slot_allocator_top: PASSED **");
    end else begin
      $display("** versioned_slot_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/vsa_pkg.sv
src/vsa_table.sv
src/vsa_ctrl.sv
src/versioned_slot_allocator_top.sv
src/vsa_checker.sv
verif/tb_versioned_slot_allocator_top.sv
